// File: hw/rtl/pgfb_pkg.sv
// Shared constants, types and helpers of the page frame buffer glyph plotter.
`timescale 1ns / 1ps

package pgfb_pkg;

    localparam int VIEW_WIDTH  = 72;
    localparam int VIEW_HEIGHT = 40;
    localparam int PAGE_COUNT  = 5;
    localparam int ROW_STRIDE  = 128;
    localparam int STORE_BYTES = PAGE_COUNT * ROW_STRIDE;
    localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int PAGE_W      = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

    // A glyph column spans at most eight rows of at most seven pixels each.
    localparam int MAX_ROWS    = 8;
    localparam int MAX_SCALE   = 7;
    localparam int PATTERN_W   = MAX_ROWS * MAX_SCALE;
    localparam int PIDX_W      = $clog2(PATTERN_W);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [3:0] HEIGHT_RESET = 4'd8;
    localparam logic [2:0] SCALE_RESET  = 3'd1;

    typedef enum logic [2:0] {
        FN_CLEAR = 3'd0,
        FN_SET   = 3'd1,
        FN_UNSET = 3'd2,
        FN_GLYPH = 3'd3,
        FN_READ  = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        CFG_HEIGHT = 2'd0,
        CFG_SCALE  = 2'd1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_SET,
        OP_UNSET,
        OP_GLYPH,
        OP_READ
    } op_t;

    typedef enum logic [2:0] {
        BK_INIT,
        BK_IDLE,
        BK_SWEEP,
        BK_PIX_WRITE,
        BK_READ_OUT,
        BK_SCAN
    } back_state_t;

    // One classified command as it travels from the front end to the back end.
    typedef struct packed {
        op_t                  op;
        logic [ADDR_W-1:0]    addr;
        logic [7:0]           mask;
        logic                 in_store;
        logic [7:0]           cx;
        logic [7:0]           y0;
        logic [PATTERN_W-1:0] pattern;
        logic [2:0]           scale;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_stat_t;

    function automatic logic [ADDR_W-1:0] store_addr(input logic [4:0] page,
                                                     input logic [7:0] col);
        store_addr = ADDR_W'(int'(page) * ROW_STRIDE + int'(col));
    endfunction

endpackage

// File: hw/rtl/pgfb_front.sv
// Front end: configuration registers and command classification.
`timescale 1ns / 1ps

module pgfb_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [2:0]          func,
    input  logic [7:0]          x_pos,
    input  logic [7:0]          y_pos,
    input  logic [3:0]          glyph_col_index,
    input  logic [7:0]          column_bits,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [3:0]          cfg_data,
    output logic                push,
    output pgfb_pkg::cmd_t      cmd
);

    logic [3:0]                     height_reg;
    logic [3:0]                     height_next;
    logic [2:0]                     scale_reg;
    logic [2:0]                     scale_next;
    logic [4:0]                     page;
    logic                           in_store;
    logic                           pixel_ok;
    logic [3:0]                     rows;
    logic [5:0]                     row_lo [pgfb_pkg::MAX_ROWS];
    logic [5:0]                     row_hi [pgfb_pkg::MAX_ROWS];
    logic [pgfb_pkg::PATTERN_W-1:0] pattern;
    logic                           keep;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        height_next = height_reg;
        scale_next  = scale_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                pgfb_pkg::CFG_HEIGHT: height_next = cfg_data;
                pgfb_pkg::CFG_SCALE:  scale_next  = cfg_data[2:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= pgfb_pkg::HEIGHT_RESET;
            scale_reg  <= pgfb_pkg::SCALE_RESET;
        end
        else
        begin
            height_reg <= height_next;
            scale_reg  <= scale_next;
        end
    end

    // The vertical pattern marks every pixel offset below the glyph origin that
    // a lit glyph row covers once it is stretched by the scale.
    always_comb
    begin
        rows = (height_reg > 4'd8) ? 4'd8 : height_reg;
        for (int r = 0; r < pgfb_pkg::MAX_ROWS; r++)
        begin
            row_lo[r] = 6'(r) * 6'(scale_reg);
            row_hi[r] = row_lo[r] + 6'(scale_reg);
        end
        for (int k = 0; k < pgfb_pkg::PATTERN_W; k++)
        begin
            pattern[k] = 1'b0;
            for (int r = 0; r < pgfb_pkg::MAX_ROWS; r++)
            begin
                if (column_bits[r] && (4'(r) < rows) && (6'(k) >= row_lo[r])
                    && (6'(k) < row_hi[r]))
                begin
                    pattern[k] = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        page     = y_pos[7:3];
        in_store = (int'(page) < pgfb_pkg::PAGE_COUNT)
                   && (int'(x_pos) < pgfb_pkg::ROW_STRIDE);
        pixel_ok = in_store && (int'(x_pos) < pgfb_pkg::VIEW_WIDTH)
                   && (int'(y_pos) < pgfb_pkg::VIEW_HEIGHT);

        cmd.op       = pgfb_pkg::OP_CLEAR;
        cmd.addr     = pgfb_pkg::store_addr(page, x_pos);
        cmd.mask     = 8'(8'd1 << y_pos[2:0]);
        cmd.in_store = in_store;
        cmd.cx       = x_pos + 8'(8'(glyph_col_index) * 8'(scale_reg));
        cmd.y0       = y_pos;
        cmd.pattern  = pattern;
        cmd.scale    = scale_reg;

        keep = 1'b0;
        case (func)
            pgfb_pkg::FN_CLEAR:
            begin
                cmd.op = pgfb_pkg::OP_CLEAR;
                keep   = 1'b1;
            end
            pgfb_pkg::FN_SET:
            begin
                cmd.op = pgfb_pkg::OP_SET;
                keep   = pixel_ok;
            end
            pgfb_pkg::FN_UNSET:
            begin
                cmd.op = pgfb_pkg::OP_UNSET;
                keep   = pixel_ok;
            end
            pgfb_pkg::FN_GLYPH:
            begin
                cmd.op = pgfb_pkg::OP_GLYPH;
                keep   = (scale_reg != 3'd0) && (pattern != '0);
            end
            pgfb_pkg::FN_READ:
            begin
                cmd.op = pgfb_pkg::OP_READ;
                keep   = 1'b1;
            end
            default: keep = 1'b0;
        endcase
    end

    assign push = accept && keep;

endmodule

// File: hw/rtl/pgfb_queue.sv
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module pgfb_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  pgfb_pkg::cmd_t        push_cmd,
    input  logic                  pop,
    output pgfb_pkg::cmd_t        head,
    output pgfb_pkg::queue_stat_t stat
);

    pgfb_pkg::cmd_t              entries [pgfb_pkg::QUEUE_DEPTH];
    logic [pgfb_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [pgfb_pkg::QPTR_W-1:0] wr_ptr_next;
    logic [pgfb_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [pgfb_pkg::QPTR_W-1:0] rd_ptr_next;
    logic [pgfb_pkg::QCNT_W-1:0] count_reg;
    logic [pgfb_pkg::QCNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == pgfb_pkg::QPTR_W'(pgfb_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == pgfb_pkg::QPTR_W'(pgfb_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head       = entries[rd_ptr_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == pgfb_pkg::QCNT_W'(pgfb_pkg::QUEUE_DEPTH));

endmodule

// File: hw/rtl/pgfb_back.sv
// Back end: frame store, clearing sweeps, read-modify-write, byte reads and glyph scan.
`timescale 1ns / 1ps

module pgfb_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pgfb_pkg::cmd_t        head,
    input  pgfb_pkg::queue_stat_t qstat,
    output logic                  pop,
    output logic                  init_busy,
    output logic                  done,
    output logic [7:0]            read_data
);

    pgfb_pkg::back_state_t          state_reg;
    pgfb_pkg::back_state_t          state_next;
    logic [pgfb_pkg::ADDR_W-1:0]    sweep_addr_reg;
    logic [pgfb_pkg::ADDR_W-1:0]    sweep_addr_next;
    logic [2:0]                     sx_reg;
    logic [2:0]                     sx_next;
    logic [pgfb_pkg::PAGE_W-1:0]    page_reg;
    logic [pgfb_pkg::PAGE_W-1:0]    page_next;
    logic                           done_reg;
    logic                           done_next;
    logic [7:0]                     read_data_reg;
    logic [7:0]                     read_data_next;

    logic [pgfb_pkg::ADDR_W-1:0]    addr_reg;
    logic [pgfb_pkg::ADDR_W-1:0]    addr_next;
    logic [7:0]                     mask_reg;
    logic [7:0]                     mask_next;
    logic                           set_reg;
    logic                           set_next;
    logic                           glyph_reg;
    logic                           glyph_next;
    logic                           in_store_reg;
    logic                           in_store_next;
    logic [7:0]                     cx_reg;
    logic [7:0]                     cx_next;
    logic [7:0]                     y0_reg;
    logic [7:0]                     y0_next;
    logic [pgfb_pkg::PATTERN_W-1:0] pattern_reg;
    logic [pgfb_pkg::PATTERN_W-1:0] pattern_next;
    logic [2:0]                     scale_reg;
    logic [2:0]                     scale_next;

    logic [7:0]                     frame_mem [pgfb_pkg::STORE_BYTES];
    logic [7:0]                     rd_data_reg;
    logic                           mem_we;
    logic [pgfb_pkg::ADDR_W-1:0]    mem_waddr;
    logic [7:0]                     mem_wdata;
    logic [pgfb_pkg::ADDR_W-1:0]    mem_raddr;

    logic [7:0]                     scan_px;
    logic                           scan_col_ok;
    logic [pgfb_pkg::ADDR_W-1:0]    scan_addr;
    logic [7:0]                     scan_yy [8];
    logic [7:0]                     scan_d [8];
    logic [7:0]                     scan_mask;
    logic                           page_last;
    logic                           sweep_last;
    logic                           scan_done;
    logic [pgfb_pkg::PAGE_W-1:0]    adv_page;
    logic [2:0]                     adv_sx;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= frame_mem[mem_raddr];
    end

    // Byte mask of the current page in the current glyph column: a row is lit when it lies
    // inside the view and its offset from the glyph origin, taken modulo 256, hits the pattern.
    always_comb
    begin
        scan_px     = cx_reg + 8'(sx_reg);
        scan_col_ok = (int'(scan_px) < pgfb_pkg::VIEW_WIDTH)
                      && (int'(scan_px) < pgfb_pkg::ROW_STRIDE);
        scan_addr   = pgfb_pkg::store_addr(5'(page_reg), scan_px);
        for (int b = 0; b < 8; b++)
        begin
            scan_yy[b]   = 8'({page_reg, 3'(b)});
            scan_d[b]    = scan_yy[b] - y0_reg;
            scan_mask[b] = (int'(scan_yy[b]) < pgfb_pkg::VIEW_HEIGHT)
                           && (int'(scan_d[b]) < pgfb_pkg::PATTERN_W)
                           && pattern_reg[scan_d[b][pgfb_pkg::PIDX_W-1:0]];
        end
        page_last  = (page_reg == pgfb_pkg::PAGE_W'(pgfb_pkg::PAGE_COUNT - 1));
        scan_done  = page_last && (sx_reg == scale_reg - 3'd1);
        adv_page   = page_last ? '0 : page_reg + 1'b1;
        adv_sx     = page_last ? sx_reg + 3'd1 : sx_reg;
        sweep_last = (sweep_addr_reg == pgfb_pkg::ADDR_W'(pgfb_pkg::STORE_BYTES - 1));
    end

    always_comb
    begin
        state_next      = state_reg;
        sweep_addr_next = sweep_addr_reg;
        sx_next         = sx_reg;
        page_next       = page_reg;
        done_next       = 1'b0;
        read_data_next  = read_data_reg;
        addr_next       = addr_reg;
        mask_next       = mask_reg;
        set_next        = set_reg;
        glyph_next      = glyph_reg;
        in_store_next   = in_store_reg;
        cx_next         = cx_reg;
        y0_next         = y0_reg;
        pattern_next    = pattern_reg;
        scale_next      = scale_reg;
        pop             = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = addr_reg;
        mem_wdata       = set_reg ? (rd_data_reg | mask_reg) : (rd_data_reg & ~mask_reg);
        mem_raddr       = addr_reg;

        case (state_reg)
            pgfb_pkg::BK_INIT, pgfb_pkg::BK_SWEEP:
            begin
                mem_we          = 1'b1;
                mem_waddr       = sweep_addr_reg;
                mem_wdata       = 8'h00;
                sweep_addr_next = sweep_addr_reg + 1'b1;
                if (sweep_last)
                begin
                    sweep_addr_next = '0;
                    state_next      = pgfb_pkg::BK_IDLE;
                end
            end
            pgfb_pkg::BK_IDLE:
            begin
                mem_raddr = head.addr;
                if (!qstat.empty)
                begin
                    pop           = 1'b1;
                    addr_next     = head.addr;
                    mask_next     = head.mask;
                    set_next      = (head.op != pgfb_pkg::OP_UNSET);
                    glyph_next    = (head.op == pgfb_pkg::OP_GLYPH);
                    in_store_next = head.in_store;
                    cx_next       = head.cx;
                    y0_next       = head.y0;
                    pattern_next  = head.pattern;
                    scale_next    = head.scale;
                    sx_next       = '0;
                    page_next     = '0;
                    case (head.op)
                        pgfb_pkg::OP_CLEAR: state_next = pgfb_pkg::BK_SWEEP;
                        pgfb_pkg::OP_SET:   state_next = pgfb_pkg::BK_PIX_WRITE;
                        pgfb_pkg::OP_UNSET: state_next = pgfb_pkg::BK_PIX_WRITE;
                        pgfb_pkg::OP_GLYPH: state_next = pgfb_pkg::BK_SCAN;
                        pgfb_pkg::OP_READ:  state_next = pgfb_pkg::BK_READ_OUT;
                        default:            state_next = pgfb_pkg::BK_IDLE;
                    endcase
                end
            end
            pgfb_pkg::BK_PIX_WRITE:
            begin
                mem_we     = 1'b1;
                state_next = pgfb_pkg::BK_IDLE;
                if (glyph_reg && !scan_done)
                begin
                    page_next  = adv_page;
                    sx_next    = adv_sx;
                    state_next = pgfb_pkg::BK_SCAN;
                end
            end
            pgfb_pkg::BK_READ_OUT:
            begin
                done_next      = 1'b1;
                read_data_next = in_store_reg ? rd_data_reg : 8'h00;
                state_next     = pgfb_pkg::BK_IDLE;
            end
            pgfb_pkg::BK_SCAN:
            begin
                mem_raddr = scan_addr;
                if (scan_col_ok && (scan_mask != 8'h00))
                begin
                    addr_next  = scan_addr;
                    mask_next  = scan_mask;
                    state_next = pgfb_pkg::BK_PIX_WRITE;
                end
                else if (scan_done)
                begin
                    state_next = pgfb_pkg::BK_IDLE;
                end
                else
                begin
                    page_next = adv_page;
                    sx_next   = adv_sx;
                end
            end
            default: state_next = pgfb_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pgfb_pkg::BK_INIT;
            sweep_addr_reg <= '0;
            sx_reg         <= '0;
            page_reg       <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_addr_reg <= sweep_addr_next;
            sx_reg         <= sx_next;
            page_reg       <= page_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        read_data_reg <= read_data_next;
        addr_reg      <= addr_next;
        mask_reg      <= mask_next;
        set_reg       <= set_next;
        glyph_reg     <= glyph_next;
        in_store_reg  <= in_store_next;
        cx_reg        <= cx_next;
        y0_reg        <= y0_next;
        pattern_reg   <= pattern_next;
        scale_reg     <= scale_next;
    end

    assign init_busy = (state_reg == pgfb_pkg::BK_INIT);
    assign done      = done_reg;
    assign read_data = read_data_reg;

endmodule

// File: hw/rtl/page_framebuffer_glyph_plotter.sv
// Top level of the page frame buffer glyph plotter.
`timescale 1ns / 1ps

// A command word is taken when start is high and busy is low; a read returns
// its byte on read_data with done high for one cycle, and the receiver cannot
// stall it. Commands pass through a two-word queue to a frame store of
// PAGE_COUNT x ROW_STRIDE bytes with one read port and one write port, so the
// store's one read and one write per cycle set the pace. The back end takes
// each word from the queue in its idle state; a set or clear pixel then writes
// its modified byte back, a read passes its byte through the result register,
// a glyph column visits scale x PAGE_COUNT byte positions and writes each byte
// with a lit row, and a clear all zeroes all 640 store bytes. busy is also
// high while the queue holds two words. After reset every store byte is swept
// to zero with busy held high. Configuration writes are taken at any time, but
// only belong while the queue is empty and no command is still running.
module page_framebuffer_glyph_plotter (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] func,
    input  logic [7:0] x_pos,
    input  logic [7:0] y_pos,
    input  logic [3:0] glyph_col_index,
    input  logic [7:0] column_bits,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [3:0] cfg_data,
    output logic       done,
    output logic [7:0] read_data
);

    logic                  accept;
    logic                  push;
    logic                  pop;
    logic                  init_busy;
    pgfb_pkg::cmd_t        push_cmd;
    pgfb_pkg::cmd_t        head;
    pgfb_pkg::queue_stat_t qstat;

    assign busy   = init_busy || qstat.full;
    assign accept = start && !busy;

    pgfb_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .func            (func),
        .x_pos           (x_pos),
        .y_pos           (y_pos),
        .glyph_col_index (glyph_col_index),
        .column_bits     (column_bits),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .push            (push),
        .cmd             (push_cmd)
    );

    pgfb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .stat     (qstat)
    );

    pgfb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .qstat     (qstat),
        .pop       (pop),
        .init_busy (init_busy),
        .done      (done),
        .read_data (read_data)
    );

endmodule

// File: hw/rtl/pgfb_checker.sv
// Port-level checks of the page frame buffer glyph plotter and their binding.
`timescale 1ns / 1ps

module pgfb_checker (
    input logic clk,
    input logic rst_n,
    input logic busy,
    input logic done
);

    // A read needs a store access and a result register, so results never
    // come in consecutive cycles.
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done asserted in two consecutive cycles");

    // Once reset has been seen at an edge, the block refuses commands and shows
    // no result at the next edge.
    assert property (@(posedge clk) !rst_n |=> (busy && !done))
        else $error("busy low or done high after reset was applied");

    // The clearing sweep after reset keeps busy high well past release.
    assert property (@(posedge clk) $rose(rst_n) |=> busy)
        else $error("busy dropped right after reset release");

    assert property (@(posedge clk) disable iff (!rst_n) $rose(rst_n) |-> !done)
        else $error("result shown right after reset release");

endmodule

bind page_framebuffer_glyph_plotter pgfb_checker u_pgfb_checker (.*);
